/* src/icep_pkg.sv */
// Package for the in-band command escape parser.
// Sizes, byte constants, reply codes, the result word and the switch pattern.
// No dependencies; the core, result register, top level and checker import it.
package icep_pkg;

    localparam int BUFFER_DEPTH  = 128;
    localparam int PAYLOAD_LIMIT = 64;
    localparam int CNT_W         = $clog2(BUFFER_DEPTH);
    localparam int STORE_MAX     = BUFFER_DEPTH - 1;
    localparam int HEAD_DEPTH    = 5;
    localparam int PRE_LAST      = 3;
    localparam int TRAILER_LEN   = 3;

    localparam logic [7:0] PRE_B0    = 8'hB1;
    localparam logic [7:0] PRE_B1    = 8'hC3;
    localparam logic [7:0] PRE_B2    = 8'hBF;
    localparam logic [7:0] PRE_B3    = 8'h3C;
    localparam logic [7:0] DELIM     = 8'h3E;
    localparam logic [7:0] TRL_B0    = 8'hC3;
    localparam logic [7:0] TRL_B1    = 8'hBF;
    localparam logic [7:0] TRL_B2    = 8'hC3;

    localparam logic [31:0] WORD_BOOT  = "boot";
    localparam logic [31:0] WORD_EXIT  = "exit";
    localparam logic [39:0] WORD_BAND1 = "band1";
    localparam logic [39:0] WORD_BAND2 = "band2";
    localparam logic [39:0] WORD_BAND3 = "band3";

    localparam logic       KIND_DATA  = 1'b0;
    localparam logic       KIND_REPLY = 1'b1;
    localparam logic       MODE_PASS  = 1'b0;
    localparam logic       MODE_BOOT  = 1'b1;
    localparam logic [1:0] BAND_24    = 2'd0;
    localparam logic [1:0] BAND_SUB1  = 2'd1;
    localparam logic [1:0] BAND_SUB2  = 2'd2;
    localparam logic [2:0] SW_24      = 3'b010;
    localparam logic [2:0] SW_SUB1    = 3'b001;
    localparam logic [2:0] SW_SUB2    = 3'b100;

    typedef enum logic [2:0] {
        REPLY_BOOT     = 3'd0,
        REPLY_EXIT     = 3'd1,
        REPLY_BAND1    = 3'd2,
        REPLY_BAND2    = 3'd3,
        REPLY_BAND3    = 3'd4,
        REPLY_UNKNOWN  = 3'd5,
        REPLY_NO_DELIM = 3'd6,
        REPLY_TOO_LONG = 3'd7
    } t_reply;

    typedef enum logic {
        PS_SCAN = 1'b0,
        PS_CMD  = 1'b1
    } t_pstate;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        t_reply     reply_code;
        logic       mode;
        logic [1:0] band;
        logic [2:0] rf_switch;
    } t_result;

    function automatic logic [7:0] preamble_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = PRE_B0;
            2'd1:    b = PRE_B1;
            2'd2:    b = PRE_B2;
            default: b = PRE_B3;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] switch_pattern(input logic [1:0] band);
        logic [2:0] sw;
        case (band)
            BAND_SUB1: sw = SW_SUB1;
            BAND_SUB2: sw = SW_SUB2;
            default:   sw = SW_24;
        endcase
        return sw;
    endfunction

endpackage

/* src/icep_ifs.sv */
// Channel interfaces of the escape parser: host byte in, result word out.
// Plain valid/ready handshake; no dependencies.
interface icep_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface icep_res_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] data_byte;
    logic [2:0] reply_code;
    logic       radio_mode;
    logic [1:0] radio_band;
    logic [2:0] rf_switch;

    modport source (output valid, output result_kind, output data_byte, output reply_code,
                    output radio_mode, output radio_band, output rf_switch, input ready);
    modport sink   (input valid, input result_kind, input data_byte, input reply_code,
                    input radio_mode, input radio_band, input rf_switch, output ready);
endinterface

/* src/icep_core.sv */
// Parser core: preamble match, command store, trailer detect, classification.
// Holds all parser state; one accepted byte updates it in the same cycle. Uses icep_pkg.
module icep_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output icep_pkg::t_result o_res
);
    import icep_pkg::*;

    t_pstate                        r_state, n_state;
    logic [1:0]                     r_pre, n_pre;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic                           r_dseen, n_dseen;
    logic [CNT_W-1:0]               r_dpos, n_dpos;
    logic [HEAD_DEPTH-1:0][7:0]     r_head, n_head;
    logic [TRAILER_LEN-1:0][7:0]    r_trail, n_trail;
    logic                           r_mode, n_mode;
    logic [1:0]                     r_band, n_band;

    logic   store_en;
    logic   pre_match;
    logic   pre_done;
    logic   trailer_hit;
    t_reply code;

    function automatic t_reply classify(input logic seen, input logic [CNT_W-1:0] pos,
                                        input logic [HEAD_DEPTH-1:0][7:0] h);
        t_reply c;
        logic [31:0] w4;
        logic [39:0] w5;
        w4 = {h[0], h[1], h[2], h[3]};
        w5 = {h[0], h[1], h[2], h[3], h[4]};
        c  = REPLY_UNKNOWN;
        if (!seen) begin
            c = REPLY_NO_DELIM;
        end else if (32'(pos) >= PAYLOAD_LIMIT) begin
            c = REPLY_TOO_LONG;
        end else if (pos == CNT_W'(HEAD_DEPTH - 1)) begin
            if (w4 == WORD_BOOT)      c = REPLY_BOOT;
            else if (w4 == WORD_EXIT) c = REPLY_EXIT;
        end else if (pos == CNT_W'(HEAD_DEPTH)) begin
            if (w5 == WORD_BAND1)      c = REPLY_BAND1;
            else if (w5 == WORD_BAND2) c = REPLY_BAND2;
            else if (w5 == WORD_BAND3) c = REPLY_BAND3;
        end
        return c;
    endfunction

    // store, delimiter and trailer tracking
    always_comb begin
        n_pre   = r_pre;
        n_cnt   = r_cnt;
        n_dseen = r_dseen;
        n_dpos  = r_dpos;
        n_head  = r_head;
        n_trail = r_trail;

        pre_match = (i_byte == preamble_byte(r_pre));
        pre_done  = pre_match && (r_pre == 2'(PRE_LAST));
        store_en  = i_accept && (r_state == PS_CMD) && (r_cnt < CNT_W'(STORE_MAX));

        if (i_accept && (r_state == PS_SCAN)) begin
            // a mismatching byte clears progress and is not retried as a first byte
            n_pre = (pre_match && !pre_done) ? r_pre + 2'd1 : 2'd0;
            if (pre_done) begin
                n_cnt   = '0;
                n_dseen = 1'b0;
                n_dpos  = '0;
            end
        end

        if (store_en) begin
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                if (r_cnt == CNT_W'(i)) n_head[i] = i_byte;
            end
            if (!r_dseen && (i_byte == DELIM)) begin
                n_dseen = 1'b1;
                n_dpos  = r_cnt;
            end
            n_trail = {r_trail[TRAILER_LEN-2:0], i_byte};
            n_cnt   = r_cnt + CNT_W'(1);
        end

        // n_trail[2] is the oldest of the last three stored bytes
        trailer_hit = store_en && (n_cnt >= CNT_W'(TRAILER_LEN))
                      && (n_trail[2] == TRL_B0) && (n_trail[1] == TRL_B1)
                      && (n_trail[0] == TRL_B2);

        if (trailer_hit) begin
            n_cnt   = '0;
            n_dseen = 1'b0;
            n_dpos  = '0;
            n_pre   = 2'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            PS_SCAN: begin
                if (i_accept && pre_done) n_state = PS_CMD;
            end
            PS_CMD: begin
                if (trailer_hit) n_state = PS_SCAN;
            end
            default: n_state = PS_SCAN;
        endcase
    end

    // classification, mode/band update and the result word
    // the closing byte is never a delimiter, so the registered delimiter state holds
    always_comb begin
        code   = classify(r_dseen, r_dpos, n_head);
        n_mode = r_mode;
        n_band = r_band;
        if (trailer_hit) begin
            case (code)
                REPLY_BOOT:  n_mode = MODE_BOOT;
                REPLY_EXIT:  n_mode = MODE_PASS;
                REPLY_BAND1: n_band = BAND_24;
                REPLY_BAND2: n_band = BAND_SUB1;
                REPLY_BAND3: n_band = BAND_SUB2;
                default:     ;
            endcase
        end

        o_res_valid      = (i_accept && (r_state == PS_SCAN) && !pre_done) || trailer_hit;
        o_res.kind       = trailer_hit ? KIND_REPLY : KIND_DATA;
        o_res.data_byte  = trailer_hit ? 8'h00 : i_byte;
        o_res.reply_code = trailer_hit ? code : REPLY_BOOT;
        o_res.mode       = n_mode;
        o_res.band       = n_band;
        o_res.rf_switch  = switch_pattern(n_band);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_SCAN;
            r_pre   <= 2'd0;
            r_cnt   <= '0;
            r_dseen <= 1'b0;
            r_dpos  <= '0;
            r_mode  <= MODE_PASS;
            r_band  <= BAND_24;
        end else begin
            r_state <= n_state;
            r_pre   <= n_pre;
            r_cnt   <= n_cnt;
            r_dseen <= n_dseen;
            r_dpos  <= n_dpos;
            r_mode  <= n_mode;
            r_band  <= n_band;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_trail <= n_trail;
    end

endmodule

/* src/icep_out_reg.sv */
// Result register of the escape parser: holds one word until the sink takes it.
// Accepts a new word in the cycle the held one leaves. Uses icep_pkg.
module icep_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  icep_pkg::t_result i_data,
    output logic              o_in_ready,
    output logic              o_valid,
    output icep_pkg::t_result o_data,
    input  logic              i_ready
);
    import icep_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_in_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) n_valid = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_valid) r_data <= i_data;
    end

endmodule

/* src/inband_command_escape_parser.sv */
// In-band command escape parser, top level.
// Instantiates icep_core and icep_out_reg; uses icep_pkg and the channel interfaces.
//
// i_rx carries host bytes; o_res carries one result word per forwarded byte or
// per completed command. Outside a command each byte is forwarded (kind 0),
// except the fourth byte of the preamble B1 C3 BF 3C, which opens a command and
// gives nothing. Inside a command bytes are stored silently until the last three
// stored are C3 BF C3; then one reply word (kind 1) carries the reply code.
// Every word also shows mode, band and RF switch lines as they stand after it.
// Latency: a word appears on o_res the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; the parser state is updated in the
// cycle the byte is taken, and the single result register decouples the two sides.
// Stall: while o_res.ready is low the held word stays, and i_rx.ready is low
// only while that register is full and not being emptied.
// Reset (synchronous, active low): no word held, preamble progress cleared,
// outside a command, passthrough mode, 2.4 GHz band.
module inband_command_escape_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icep_rx_if.sink     i_rx,
    icep_res_if.source  o_res
);
    import icep_pkg::*;

    logic    accept;
    logic    in_ready;
    logic    core_valid;
    t_result core_res;
    t_result out_res;

    assign accept     = i_rx.valid && in_ready;
    assign i_rx.ready = in_ready;

    icep_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    icep_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (core_valid),
        .i_data     (core_res),
        .o_in_ready (in_ready),
        .o_valid    (o_res.valid),
        .o_data     (out_res),
        .i_ready    (o_res.ready)
    );

    assign o_res.result_kind = out_res.kind;
    assign o_res.data_byte   = out_res.data_byte;
    assign o_res.reply_code  = out_res.reply_code;
    assign o_res.radio_mode  = out_res.mode;
    assign o_res.radio_band  = out_res.band;
    assign o_res.rf_switch   = out_res.rf_switch;

endmodule

/* src/icep_checker.sv */
// Port-level checks for the escape parser, bound to the top level.
// Watches the channel handshakes and result fields only; uses icep_pkg.
module icep_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       i_rx_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_kind,
    input logic [7:0] i_data_byte,
    input logic [2:0] i_reply_code,
    input logic       i_mode,
    input logic [1:0] i_band,
    input logic [2:0] i_switch
);
    import icep_pkg::*;

    // held word must not change while the sink stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
        && $stable({i_kind, i_data_byte, i_reply_code, i_mode, i_band, i_switch}))
        else $error("result word changed under stall");

    // the input side only stalls when the result register is full
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_rx_ready)
        else $error("input stalled with empty result register");

    // a fresh word needs a byte taken on the previous edge
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !$past(i_res_valid) |-> $past(i_rx_valid && i_rx_ready))
        else $error("result word without an accepted byte");

    // switch lines follow the band, and unused fields are zero
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
        ((i_band == BAND_24 && i_switch == SW_24)
         || (i_band == BAND_SUB1 && i_switch == SW_SUB1)
         || (i_band == BAND_SUB2 && i_switch == SW_SUB2))
        && (i_kind == KIND_REPLY || i_reply_code == REPLY_BOOT)
        && (i_kind == KIND_DATA || i_data_byte == 8'h00))
        else $error("inconsistent result fields");

endmodule

bind inband_command_escape_parser icep_checker u_icep_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_valid   (i_rx.valid),
    .i_rx_ready   (i_rx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_kind       (o_res.result_kind),
    .i_data_byte  (o_res.data_byte),
    .i_reply_code (o_res.reply_code),
    .i_mode       (o_res.radio_mode),
    .i_band       (o_res.radio_band),
    .i_switch     (o_res.rf_switch)
);
